// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants, state codes and the divider request for the DMC bit
// predictor.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int NODES_DEF   = 262144;
	localparam int CNT_W       = 17;
	localparam int THR_W       = 16;
	localparam int FRAC_W      = 28;
	localparam int FRAC_SH     = 11;
	localparam int DECAY_SH    = 6;
	localparam int Q_SH        = 16;
	localparam int BRAID_NODES = 65280;
	localparam int TREE_LAST   = 254;
	localparam int TREE_INNER  = 127;
	localparam int TREE_NODES  = 255;
	localparam int INIT_HI     = 2048;
	localparam int INIT_LO     = 512;
	localparam int INIT_LIMIT  = 1024;
	localparam int BIT_INC     = 1024;
	localparam int THR_CAP     = 8 * 1024;

	// serial divider operand widths
	localparam int DIV_NW = 34;
	localparam int DIV_DW = 19;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef enum logic [17:0] {
		ST_IDLE  = 18'h00001,
		ST_SWEEP = 18'h00002,
		ST_RDCUR = 18'h00004,
		ST_UPD   = 18'h00008,
		ST_RDNXT = 18'h00010,
		ST_CHK   = 18'h00020,
		ST_MUL0  = 18'h00040,
		ST_DIV0  = 18'h00080,
		ST_MUL1  = 18'h00100,
		ST_DIV1  = 18'h00200,
		ST_WRNW  = 18'h00400,
		ST_WRNXT = 18'h00800,
		ST_WRCUR = 18'h01000,
		ST_RDOUT = 18'h02000,
		ST_OUTD  = 18'h04000,
		ST_PST   = 18'h08000,
		ST_PWAIT = 18'h10000,
		ST_FIN   = 18'h20000
	} state_t;

endpackage

// ===== rtl/dmc_bit_predictor_with_cloning.sv =====
// ----------------------------------------------------------------------------
// dmc_bit_predictor_with_cloning
// Dynamic Markov bit predictor over a node table with clone allocation.
//
//   channel | signals                          | dir | word
//   --------+----------------------------------+-----+---------------------
//   in      | in_valid, in_ready               | in  | kind, bit_req
//   out     | out_valid, out_ready             | out | prob, counts, node,
//           |                                  |     | nodes_used, flags
//   cfg     | cfg_we, cfg_wdata                | in  | start threshold
//
// A learn word reads and updates the current node, reads the node it moves to
// and runs the probability divide, then loads the result. Reading the successor
// adds a clone test; a clone adds two more divides and three node writes.
// in_ready returns together with the loaded result. A rebuild word sweeps the
// braid region (65280 nodes) and then takes the same read and divide; reset
// runs the sweep before in_ready rises. The sequencer stalls on a full output
// register and while it waits for the divider.
// ----------------------------------------------------------------------------
module dmc_bit_predictor_with_cloning import dmc_pkg::*; #(
	parameter int NODES = NODES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic             bit_req,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      prob_one_q16,
	output logic [16:0]      count_zero,
	output logic [16:0]      count_one,
	output logic [17:0]      current_node,
	output logic [18:0]      nodes_used,
	output logic             cloned,
	output logic             table_full,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(NODES);
	localparam int EW = 2 * CNT_W + 2 * AW;

	state_t              state_q;
	logic [THR_W-1:0]    cfg_q;
	logic [THR_W-1:0]    thr_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [CNT_W-1:0]    init_q;
	logic [AW-1:0]       cur_q;
	logic [AW:0]         nf_q;
	logic                reb_q;
	logic [AW-1:0]       pos_q;
	logic [7:0]          k_q;

	logic                y_q;
	logic [CNT_W-1:0]    count_q, u0_q, u1_q, b0_q, b1_q, s0_q, s1_q, z_q, o_q;
	logic [AW-1:0]       l0_q, l1_q, nl0_q, nl1_q, nxt_q;
	logic [CNT_W:0]      tot_q;
	logic [DIV_NW-1:0]   prod_q;
	logic [15:0]         p_q;
	logic                cloned_q, full_q;

	logic                out_valid_q;
	logic                out_load;
	logic [15:0]         prob_q;
	logic [16:0]         cz_q, co_q;
	logic [17:0]         node_q;
	logic [18:0]         used_q;
	logic                cl_q, tf_q;

	// memory ports
	logic                we;
	logic [AW-1:0]       waddr, raddr;
	logic [EW-1:0]       wdata, rdata;
	logic [CNT_W-1:0]    r_c0, r_c1;
	logic [AW-1:0]       r_l0, r_l1;

	div_req_t            dreq;
	logic                ddone;
	logic [DIV_NW-1:0]   dquo;

	dmc_node_ram #(.AW(AW), .EW(EW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	dmc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (ddone),
		.quo    (dquo)
	);

	assign r_c0 = rdata[EW-1 -: CNT_W];
	assign r_c1 = rdata[EW-1-CNT_W -: CNT_W];
	assign r_l0 = rdata[2*AW-1 -: AW];
	assign r_l1 = rdata[AW-1:0];

	// count decay and update of the current node
	logic [CNT_W+DECAY_SH-1:0] m0, m1;
	logic [CNT_W-1:0]          u0, u1, cnt_sel;
	always_comb begin
		m0      = {r_c0, DECAY_SH'(0)} - (CNT_W+DECAY_SH)'(r_c0);
		m1      = {r_c1, DECAY_SH'(0)} - (CNT_W+DECAY_SH)'(r_c1);
		u0      = m0[CNT_W+DECAY_SH-1:DECAY_SH] + (y_q ? '0 : CNT_W'(BIT_INC));
		u1      = m1[CNT_W+DECAY_SH-1:DECAY_SH] + (y_q ? CNT_W'(BIT_INC) : '0);
		cnt_sel = y_q ? r_c1 : r_c0;
	end

	// clone test on the successor
	logic [CNT_W:0] tot, lim;
	assign tot = {1'b0, r_c0} + {1'b0, r_c1};
	assign lim = {1'b0, count_q} + (CNT_W+1)'(thr_q);

	// braid layout for the sweep
	logic [6:0]    jj;
	logic [AW-1:0] root, bl0, bl1;
	always_comb begin
		jj   = 7'(k_q - 8'(TREE_INNER));
		root = AW'({jj, 9'b0}) - AW'({jj, 1'b0});
		if (k_q < 8'(TREE_INNER)) begin
			bl0 = pos_q + AW'(k_q) + AW'(1);
			bl1 = pos_q + AW'(k_q) + AW'(2);
		end else begin
			bl0 = root;
			bl1 = root + AW'(TREE_NODES);
		end
	end

	// write port and read address
	always_comb begin
		we    = 1'b0;
		waddr = cur_q;
		wdata = {u0_q, u1_q, l0_q, l1_q};
		raddr = cur_q;
		unique case (state_q)
			ST_SWEEP: begin
				we    = 1'b1;
				waddr = pos_q;
				wdata = {init_q, init_q, bl0, bl1};
			end
			ST_UPD: begin
				we    = 1'b1;
				wdata = {u0, u1, r_l0, r_l1};
			end
			ST_WRNW: begin
				we    = 1'b1;
				waddr = nf_q[AW-1:0];
				wdata = {s0_q, s1_q, nl0_q, nl1_q};
			end
			ST_WRNXT: begin
				we    = 1'b1;
				waddr = nxt_q;
				wdata = {b0_q - s0_q, b1_q - s1_q, nl0_q, nl1_q};
			end
			ST_WRCUR: begin
				we    = 1'b1;
				wdata = {u0_q, u1_q, y_q ? l0_q : nf_q[AW-1:0],
					y_q ? nf_q[AW-1:0] : l1_q};
			end
			ST_RDNXT: raddr = nxt_q;
			default: ;
		endcase
	end

	// divider request
	always_comb begin
		dreq.start = (state_q == ST_MUL0) || (state_q == ST_MUL1) || (state_q == ST_PST);
		if (state_q == ST_PST) begin
			dreq.num = {(CNT_W+1)'(o_q) + (CNT_W+1)'(1), Q_SH'(0)};
			dreq.den = DIV_DW'(z_q) + DIV_DW'(o_q) + DIV_DW'(2);
		end else begin
			dreq.num = prod_q;
			dreq.den = DIV_DW'(tot_q);
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// result register free or draining this cycle
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			cfg_q       <= THR_W'(256);
			thr_q       <= THR_W'(256);
			frac_q      <= FRAC_W'(256) << FRAC_SH;
			init_q      <= CNT_W'(INIT_HI);
			cur_q       <= '0;
			nf_q        <= (AW+1)'(BRAID_NODES);
			reb_q       <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
			cloned_q    <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cloned_q <= 1'b0;
						full_q   <= 1'b0;
						y_q      <= bit_req;
						if (kind) begin
							init_q  <= (cfg_q < THR_W'(INIT_LIMIT)) ? CNT_W'(INIT_HI)
								: CNT_W'(INIT_LO);
							thr_q   <= cfg_q;
							frac_q  <= FRAC_W'(cfg_q) << FRAC_SH;
							cur_q   <= '0;
							nf_q    <= (AW+1)'(BRAID_NODES);
							reb_q   <= 1'b1;
							pos_q   <= '0;
							k_q     <= '0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_RDCUR;
						end
					end
				end
				ST_SWEEP: begin
					pos_q <= pos_q + AW'(1);
					k_q   <= (k_q == 8'(TREE_LAST)) ? 8'd0 : k_q + 8'd1;
					if (pos_q == AW'(BRAID_NODES - 1)) begin
						state_q <= reb_q ? ST_RDOUT : ST_IDLE;
					end
				end
				ST_RDCUR: state_q <= ST_UPD;
				ST_UPD: begin
					u0_q    <= u0;
					u1_q    <= u1;
					l0_q    <= r_l0;
					l1_q    <= r_l1;
					count_q <= cnt_sel;
					nxt_q   <= y_q ? r_l1 : r_l0;
					if (cnt_sel > CNT_W'(thr_q)) begin
						state_q <= ST_RDNXT;
					end else begin
						cur_q   <= y_q ? r_l1 : r_l0;
						state_q <= ST_RDOUT;
					end
				end
				ST_RDNXT: state_q <= ST_CHK;
				ST_CHK: begin
					b0_q   <= r_c0;
					b1_q   <= r_c1;
					nl0_q  <= r_l0;
					nl1_q  <= r_l1;
					tot_q  <= tot;
					prod_q <= DIV_NW'(r_c0) * DIV_NW'(count_q);
					if (tot > lim && nf_q < (AW+1)'(NODES)) begin
						state_q <= ST_MUL0;
					end else begin
						full_q  <= (tot > lim);
						cur_q   <= nxt_q;
						state_q <= ST_RDOUT;
					end
				end
				ST_MUL0: state_q <= ST_DIV0;
				ST_DIV0: begin
					if (ddone) begin
						s0_q    <= dquo[CNT_W-1:0];
						prod_q  <= DIV_NW'(b1_q) * DIV_NW'(count_q);
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_DIV1;
				ST_DIV1: begin
					if (ddone) begin
						s1_q    <= dquo[CNT_W-1:0];
						state_q <= ST_WRNW;
					end
				end
				ST_WRNW:  state_q <= ST_WRNXT;
				ST_WRNXT: state_q <= ST_WRCUR;
				ST_WRCUR: begin
					cur_q    <= nf_q[AW-1:0];
					nf_q     <= nf_q + (AW+1)'(1);
					cloned_q <= 1'b1;
					if (thr_q < THR_W'(THR_CAP)) begin
						frac_q <= frac_q + FRAC_W'(1);
						thr_q  <= THR_W'((frac_q + FRAC_W'(1)) >> FRAC_SH);
					end
					state_q <= ST_RDOUT;
				end
				ST_RDOUT: state_q <= ST_OUTD;
				ST_OUTD: begin
					z_q     <= r_c0;
					o_q     <= r_c1;
					reb_q   <= 1'b0;
					state_q <= ST_PST;
				end
				ST_PST: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					if (ddone) begin
						p_q     <= dquo[15:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			prob_q <= p_q;
			cz_q   <= z_q;
			co_q   <= o_q;
			node_q <= 18'(cur_q);
			used_q <= 19'(nf_q);
			cl_q   <= cloned_q;
			tf_q   <= full_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign prob_one_q16 = prob_q;
	assign count_zero   = cz_q;
	assign count_one    = co_q;
	assign current_node = node_q;
	assign nodes_used   = used_q;
	assign cloned       = cl_q;
	assign table_full   = tf_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("in_ready outside idle");
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cloned && table_full))
		else $error("clone and full together");
	a_nf_floor: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q >= (AW+1)'(BRAID_NODES) && nf_q <= (AW+1)'(NODES))
		else $error("free pointer out of range");
	a_clone_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRNW |-> nf_q < (AW+1)'(NODES))
		else $error("clone with full table");

endmodule

// ===== rtl/dmc_node_ram.sv =====
// ----------------------------------------------------------------------------
// dmc_node_ram
// Node table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dmc_node_ram import dmc_pkg::*; #(
	parameter int AW = 18,
	parameter int EW = 70
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [EW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [EW-1:0] rdata
);

	logic [EW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/dmc_divider.sv =====
// ----------------------------------------------------------------------------
// dmc_divider
// Restoring divider, one quotient bit per cycle, shared by the clone split
// and the probability.
// ----------------------------------------------------------------------------
module dmc_divider import dmc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW-1:0] rem_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   sh;
	logic              qbit;

	// trial subtract
	always_comb begin
		sh   = {rem_q, num_q[DIV_NW-1]};
		qbit = (sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts into the numerator register
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], qbit};
			rem_q <= qbit ? DIV_DW'(sh - {1'b0, den_q}) : sh[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule
